FILE: src/lbp_pkg.sv
// Shared types and constants for the LED blink/pulse pattern generator.
// No dependencies; imported by every module under src.
`timescale 1ns / 1ps

package lbp_pkg;

    // Elapsed-time counter width and fade step size
    localparam int TIMER_WIDTH = 16;
    localparam int FADE_STEP   = 5;

    localparam int IVL_WIDTH = 16;
    localparam int CMP_WIDTH = (TIMER_WIDTH > IVL_WIDTH) ? TIMER_WIDTH : IVL_WIDTH;

    localparam logic [7:0] DUTY_MAX = 8'd255;
    localparam logic [7:0] DUTY_MIN = 8'd0;

    // Item kinds
    localparam logic [1:0] MODE_TICK       = 2'd0;
    localparam logic [1:0] MODE_SET_PAT    = 2'd1;
    localparam logic [1:0] MODE_SET_BRIGHT = 2'd2;

    // Pattern codes
    localparam logic [2:0] PAT_OFF   = 3'd0;
    localparam logic [2:0] PAT_ON    = 3'd1;
    localparam logic [2:0] PAT_SLOW  = 3'd2;
    localparam logic [2:0] PAT_FAST  = 3'd3;
    localparam logic [2:0] PAT_PULSE = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_SLOW_IVL  = 2'd0;
    localparam logic [1:0] CFG_FAST_IVL  = 2'd1;
    localparam logic [1:0] CFG_PULSE_IVL = 2'd2;

    localparam logic [IVL_WIDTH-1:0] SLOW_IVL_RST  = 16'd1000;
    localparam logic [IVL_WIDTH-1:0] FAST_IVL_RST  = 16'd200;
    localparam logic [IVL_WIDTH-1:0] PULSE_IVL_RST = 16'd20;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] pattern;
        logic [7:0] brightness_value;
    } t_in_item;

    typedef struct packed {
        logic       led_level;
        logic [7:0] pwm_duty;
        logic       pwm_active;
        logic       pin_written;
        logic       pattern_active;
    } t_out_item;

    typedef struct packed {
        logic [IVL_WIDTH-1:0] slow_ivl;
        logic [IVL_WIDTH-1:0] fast_ivl;
        logic [IVL_WIDTH-1:0] pulse_ivl;
    } t_cfg;

endpackage

FILE: src/lbp_cfg_regs.sv
// Interval configuration registers of the LED pattern generator.
// Depends on lbp_pkg for register indexes, reset values and the t_cfg struct.
`timescale 1ns / 1ps

module lbp_cfg_regs (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic [1:0]               i_wr_index,
    input  logic [lbp_pkg::IVL_WIDTH-1:0] i_wr_data,
    output lbp_pkg::t_cfg            o_cfg
);
    import lbp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slow_ivl  <= SLOW_IVL_RST;
            r_cfg.fast_ivl  <= FAST_IVL_RST;
            r_cfg.pulse_ivl <= PULSE_IVL_RST;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                CFG_SLOW_IVL:  r_cfg.slow_ivl  <= i_wr_data;
                CFG_FAST_IVL:  r_cfg.fast_ivl  <= i_wr_data;
                CFG_PULSE_IVL: r_cfg.pulse_ivl <= i_wr_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/lbp_core.sv
// Pattern state and per-word update logic: timer, blink toggle, fade ramp.
// Depends on lbp_pkg; driven from the input register of the top level.
`timescale 1ns / 1ps

module lbp_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  lbp_pkg::t_in_item  i_item,
    input  lbp_pkg::t_cfg      i_cfg,
    output lbp_pkg::t_out_item o_result
);
    import lbp_pkg::*;

    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
    localparam logic [8:0] STEP9 = 9'(FADE_STEP);
    localparam logic [7:0] STEP8 = 8'(FADE_STEP);

    logic [2:0]             r_pattern, n_pattern;
    logic [TIMER_WIDTH-1:0] r_elapsed, n_elapsed;
    logic                   r_level, n_level;
    logic [7:0]             r_duty, n_duty;
    logic                   r_rising, n_rising;
    logic                   r_pwm, n_pwm;
    logic                   w_wrote;

    logic [TIMER_WIDTH-1:0] w_elapsed_inc;
    logic [IVL_WIDTH-1:0]   w_ivl;
    logic                   w_due;
    logic [8:0]             w_duty_up;

    always_comb begin
        w_elapsed_inc = (r_elapsed == TIMER_MAX) ? r_elapsed : r_elapsed + 1'b1;
        w_ivl = (r_pattern == PAT_SLOW) ? i_cfg.slow_ivl :
                (r_pattern == PAT_FAST) ? i_cfg.fast_ivl : i_cfg.pulse_ivl;
        w_due = CMP_WIDTH'(w_elapsed_inc) >= CMP_WIDTH'(w_ivl);
        w_duty_up = {1'b0, r_duty} + STEP9;
    end

    always_comb begin
        n_pattern = r_pattern;
        n_elapsed = r_elapsed;
        n_level   = r_level;
        n_duty    = r_duty;
        n_rising  = r_rising;
        n_pwm     = r_pwm;
        w_wrote   = 1'b0;
        unique case (i_item.mode)
            MODE_TICK: begin
                n_elapsed = w_elapsed_inc;
                if ((r_pattern == PAT_SLOW || r_pattern == PAT_FAST) && w_due) begin
                    n_level   = ~r_level;
                    n_pwm     = 1'b0;
                    w_wrote   = 1'b1;
                    n_elapsed = '0;
                end else if (r_pattern == PAT_PULSE && w_due) begin
                    if (r_rising) begin
                        if (w_duty_up >= {1'b0, DUTY_MAX}) begin
                            n_duty   = DUTY_MAX;
                            n_rising = 1'b0;
                        end else begin
                            n_duty = w_duty_up[7:0];
                        end
                    end else begin
                        // falling: clamp when the step would reach or pass zero
                        if (r_duty <= STEP8) begin
                            n_duty   = DUTY_MIN;
                            n_rising = 1'b1;
                        end else begin
                            n_duty = r_duty - STEP8;
                        end
                    end
                    n_pwm     = 1'b1;
                    w_wrote   = 1'b1;
                    n_elapsed = '0;
                end
            end
            MODE_SET_PAT: begin
                if (i_item.pattern <= PAT_PULSE && i_item.pattern != r_pattern) begin
                    n_pattern = i_item.pattern;
                    n_elapsed = '0;
                    if (i_item.pattern == PAT_OFF || i_item.pattern == PAT_ON) begin
                        n_level = (i_item.pattern == PAT_ON);
                        n_pwm   = 1'b0;
                        w_wrote = 1'b1;
                    end else if (i_item.pattern == PAT_PULSE) begin
                        n_duty   = DUTY_MIN;
                        n_rising = 1'b1;
                    end
                end
            end
            MODE_SET_BRIGHT: n_duty = i_item.brightness_value;
            default: ;  // reserved mode: state unchanged
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= PAT_OFF;
            r_elapsed <= '0;
            r_level   <= 1'b0;
            r_duty    <= DUTY_MIN;
            r_rising  <= 1'b1;
            r_pwm     <= 1'b0;
        end else if (i_en) begin
            r_pattern <= n_pattern;
            r_elapsed <= n_elapsed;
            r_level   <= n_level;
            r_duty    <= n_duty;
            r_rising  <= n_rising;
            r_pwm     <= n_pwm;
        end
    end

    always_comb begin
        o_result.led_level      = n_level;
        o_result.pwm_duty       = n_duty;
        o_result.pwm_active     = n_pwm;
        o_result.pin_written    = w_wrote;
        o_result.pattern_active = (n_pattern != PAT_OFF);
    end

    a_pulse_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_item.mode == MODE_SET_PAT && i_item.pattern == PAT_PULSE
         && r_pattern != PAT_PULSE) |=> (r_duty == DUTY_MIN && r_rising))
        else $error("pulse entry did not restart fade");

    a_write_clears_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && w_wrote) |=> (r_elapsed == '0))
        else $error("pin write left elapsed counter running");

    a_timer_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_item.mode == MODE_TICK && r_pattern == PAT_ON
         && r_elapsed == TIMER_MAX) |=> (r_elapsed == TIMER_MAX))
        else $error("elapsed counter wrapped");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> ($stable(r_pattern) && $stable(r_elapsed) && $stable(r_duty)))
        else $error("state changed without a word");

endmodule

FILE: src/led_blink_pulse_pattern_generator_unit.sv
// Top level of the LED blink/pulse pattern generator: handshake registers around lbp_core.
// Depends on lbp_pkg, lbp_cfg_regs and lbp_core.
`timescale 1ns / 1ps

// LED pattern engine. Each input word is a tick, a pattern change
// (off, on, slow blink, fast blink, pulse) or a brightness setting, and
// yields exactly one result word describing the LED afterwards. Throughput
// is one word per clock while the output side does not hold off; the path
// holds two register stages (input register, then the pattern update
// feeding the result register). The only feedback loop is the pattern
// state itself (timer increment, interval compare, fade step), so
// back-to-back words never stall unless the output side holds off. The
// output register frees the input side: a new word is taken while a finished
// result still waits as long as the input register is empty or the output
// slot drains in the same cycle. Interval registers are written through the
// cfg channel (index 0 slow, 1 fast, 2 pulse; index 3 is ignored), which is
// always ready; write them only while no word is in flight.

module led_blink_pulse_pattern_generator_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  lbp_pkg::t_in_item     i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output lbp_pkg::t_out_item    o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [lbp_pkg::IVL_WIDTH-1:0] i_cfg_data
);
    import lbp_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      w_advance;   // word in input reg moves through the core this cycle
    logic      w_in_take;
    t_cfg      w_cfg;
    t_out_item w_result;

    // Output slot is free when empty or being drained this cycle
    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign w_in_take   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    lbp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    lbp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_advance),
        .i_item   (r_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_item <= i_in_item;
        end
        if (w_advance) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_in_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while both stages blocked");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("advanced word produced no result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_valid && !r_out_valid) |=> !r_out_valid)
        else $error("result appeared without a word");

endmodule
